// ===== rtl/core/bipartite_butterfly_counter_top_defines.svh =====
// Assertion macros for the bipartite butterfly counter.
// Included by the top level only; depends on nothing else.
`ifndef BIPARTITE_BUTTERFLY_COUNTER_TOP_DEFINES_SVH
`define BIPARTITE_BUTTERFLY_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BBC_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("bbc: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BBC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("bbc: next-cycle check failed");

`endif

// ===== rtl/core/bbc_pkg.sv =====
// Shared types, constants and helpers for the bipartite butterfly counter.
// No dependencies; imported by the pair unit, the sequencer, the top level and the testbench.
package bbc_pkg;

  localparam int MAX_LEFT_DEF  = 64;
  localparam int MAX_RIGHT_DEF = 64;

  localparam int VTX_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 22;
  localparam int CHUNK_W   = 32;
  localparam int PC_W      = $clog2(CHUNK_W + 1);

  localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]     CFG_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_IN_USE = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_A_ISSUE,
    ST_A_CAPTURE,
    ST_B_ISSUE,
    ST_B_CAPTURE,
    ST_POP,
    ST_TRI,
    ST_ACC,
    ST_FINISH
  } bbc_state_t;

  typedef struct packed {
    logic load_a;
    logic load_pair;
    logic pop_step;
    logic tri_step;
    logic acc_step;
    logic clear_total;
  } pair_ctrl_t;

  function automatic logic [PC_W-1:0] popcount_chunk(input logic [CHUNK_W-1:0] v);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      n = n + PC_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/bbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/bbc_pair_unit.sv =====
// Shared pair unit: chunked popcount of two rows' intersection, C(c,2), saturating sum.
// Depends on bbc_pkg.
module bbc_pair_unit #(
  parameter int MAX_RIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bbc_pkg::pair_ctrl_t           ctl,
  input  logic [MAX_RIGHT-1:0]          rd_data,
  output logic                          chunk_last,
  output logic [bbc_pkg::COUNT_W-1:0]   total
);
  import bbc_pkg::*;

  localparam int CHUNKS = (MAX_RIGHT + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W  = CHUNKS * CHUNK_W;
  localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CW     = $clog2(MAX_RIGHT + 1);

  logic [MAX_RIGHT-1:0] row_a;
  logic [PAD_W-1:0]     and_row;
  logic [CHW-1:0]       chunk;
  logic [CW-1:0]        common;
  logic [2*CW-1:0]      prod;
  logic [COUNT_W:0]     sum;

  assign chunk_last = (chunk == CHW'(CHUNKS - 1));
  assign sum = (COUNT_W+1)'(total) + (COUNT_W+1)'(prod[2*CW-1:1]);

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      row_a <= rd_data;
    end
    if (ctl.load_pair) begin
      and_row <= PAD_W'(row_a & rd_data);
      common  <= '0;
      chunk   <= '0;
    end else if (ctl.pop_step) begin
      common  <= common + CW'(popcount_chunk(and_row[CHUNK_W-1:0]));
      and_row <= and_row >> CHUNK_W;
      chunk   <= chunk + CHW'(1);
    end
    if (ctl.tri_step) begin
      if (common == '0) begin
        prod <= '0;
      end else begin
        prod <= (2*CW)'(common) * (2*CW)'(common - CW'(1));
      end
    end
  end

  // Saturate the running total; monotone, so clamping each step equals clamping at the end.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_total) begin
      total <= '0;
    end else if (ctl.acc_step) begin
      if (sum > (COUNT_W+1)'(COUNT_MAX)) begin
        total <= COUNT_MAX;
      end else begin
        total <= sum[COUNT_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/bbc_ctrl.sv =====
// Sequencer: edge loading by read-modify-write, row valid bits, pair sweep control.
// Depends on bbc_pkg.
module bbc_ctrl #(
  parameter int MAX_LEFT  = 64,
  parameter int MAX_RIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bbc_pkg::VTX_W-1:0]     left_vertex,
  input  logic [bbc_pkg::VTX_W-1:0]     right_vertex,
  input  logic                          last_edge,
  input  logic [bbc_pkg::CFG_W-1:0]     left_in_use,
  input  logic [bbc_pkg::CFG_W-1:0]     right_in_use,
  output logic                          ram_wr_en,
  output logic [$clog2(MAX_LEFT)-1:0]   ram_wr_addr,
  output logic [MAX_RIGHT-1:0]          ram_wr_data,
  output logic [$clog2(MAX_LEFT)-1:0]   ram_rd_addr,
  input  logic [MAX_RIGHT-1:0]          ram_rd_data,
  output bbc_pkg::pair_ctrl_t           pair_ctl,
  input  logic                          chunk_last,
  input  logic                          res_busy,
  output logic                          res_load,
  output logic                          res_dropped
);
  import bbc_pkg::*;

  localparam int LW = $clog2(MAX_LEFT);
  localparam int RW = $clog2(MAX_RIGHT);
  localparam logic [LW-1:0] LAST_A = LW'(MAX_LEFT - 2);
  localparam logic [LW-1:0] LAST_B = LW'(MAX_LEFT - 1);

  bbc_state_t state, state_next;

  logic [LW-1:0]       lv_q;
  logic [RW-1:0]       rv_q;
  logic                last_q;
  logic [LW-1:0]       ca;
  logic [LW-1:0]       cb;
  logic [MAX_LEFT-1:0] row_valid;
  logic                rd_valid_q;
  logic                dropped;

  logic [LW+VTX_W-1:0] lv_ext;
  logic [RW+VTX_W-1:0] rv_ext;
  logic                in_range;
  logic                accept;
  logic                a_ok, b_ok, a_last, b_last;
  logic [MAX_RIGHT-1:0] base_row;

  assign lv_ext   = {{LW{1'b0}}, left_vertex};
  assign rv_ext   = {{RW{1'b0}}, right_vertex};
  assign in_range = ({1'b0, left_vertex} < left_in_use)
                 && ({3'b000, left_vertex} < 9'(MAX_LEFT))
                 && ({1'b0, right_vertex} < right_in_use)
                 && ({3'b000, right_vertex} < 9'(MAX_RIGHT));
  assign accept   = in_valid && in_ready;

  assign a_ok   = row_valid[ca];
  assign b_ok   = row_valid[cb];
  assign a_last = (ca == LAST_A);
  assign b_last = (cb == LAST_B);

  assign base_row    = rd_valid_q ? ram_rd_data : '0;
  assign ram_wr_addr = lv_q;
  assign ram_wr_data = base_row | ({{(MAX_RIGHT-1){1'b0}}, 1'b1} << rv_q);
  assign res_dropped = dropped;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_range) begin
            state_next = ST_EDGE_WR;
          end else if (last_edge) begin
            state_next = ST_A_ISSUE;
          end
        end
      end
      ST_EDGE_WR:   state_next = last_q ? ST_A_ISSUE : ST_IDLE;
      ST_A_ISSUE: begin
        if (a_ok) begin
          state_next = ST_A_CAPTURE;
        end else if (a_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_A_CAPTURE: state_next = ST_B_ISSUE;
      ST_B_ISSUE: begin
        if (b_ok) begin
          state_next = ST_B_CAPTURE;
        end else if (b_last) begin
          state_next = a_last ? ST_FINISH : ST_A_ISSUE;
        end
      end
      ST_B_CAPTURE: state_next = ST_POP;
      ST_POP:       state_next = chunk_last ? ST_TRI : ST_POP;
      ST_TRI:       state_next = ST_ACC;
      ST_ACC: begin
        if (b_last) begin
          state_next = a_last ? ST_FINISH : ST_A_ISSUE;
        end else begin
          state_next = ST_B_ISSUE;
        end
      end
      ST_FINISH:    state_next = res_busy ? ST_FINISH : ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_rd_addr = ca;
    pair_ctl    = '0;
    res_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ram_rd_addr = lv_ext[LW-1:0];
      end
      ST_EDGE_WR:   ram_wr_en = 1'b1;
      ST_A_ISSUE:   ram_rd_addr = ca;
      ST_A_CAPTURE: pair_ctl.load_a = 1'b1;
      ST_B_ISSUE:   ram_rd_addr = cb;
      ST_B_CAPTURE: pair_ctl.load_pair = 1'b1;
      ST_POP:       pair_ctl.pop_step = 1'b1;
      ST_TRI:       pair_ctl.tri_step = 1'b1;
      ST_ACC:       pair_ctl.acc_step = 1'b1;
      ST_FINISH: begin
        res_load             = !res_busy;
        pair_ctl.clear_total = !res_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Edge capture and read-valid tracking
  always_ff @(posedge clk) begin
    rd_valid_q <= row_valid[ram_rd_addr];
    if (accept) begin
      lv_q   <= lv_ext[LW-1:0];
      rv_q   <= rv_ext[RW-1:0];
      last_q <= last_edge;
    end
  end

  // Row valid bits and dropped flag; both drop back to empty once a result is loaded
  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      row_valid <= '0;
      dropped   <= 1'b0;
    end else begin
      if (state == ST_EDGE_WR) begin
        row_valid[lv_q] <= 1'b1;
      end
      if (accept && !in_range) begin
        dropped <= 1'b1;
      end
    end
  end

  // Sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ca <= '0;
      cb <= '0;
    end else begin
      priority case (state)
        ST_IDLE: ca <= '0;
        ST_A_ISSUE: begin
          if (a_ok) begin
            cb <= ca + LW'(1);
          end else if (!a_last) begin
            ca <= ca + LW'(1);
          end
        end
        ST_B_ISSUE, ST_ACC: begin
          if (state == ST_ACC || !b_ok) begin
            if (!b_last) begin
              cb <= cb + LW'(1);
            end else if (!a_last) begin
              ca <= ca + LW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/bipartite_butterfly_counter_top.sv =====
// Bipartite butterfly counter: top level with configuration registers and result register.
// Depends on bbc_pkg, bbc_ram, bbc_pair_unit, bbc_ctrl and the assertion macro header.
//
// Edges of a bipartite graph arrive one request at a time (left_vertex, right_vertex) and
// are stored as bits of an adjacency matrix held in a RAM of MAX_LEFT rows by MAX_RIGHT
// bits. An in-range edge is stored by a row read in the idle state, then a row write in
// the edge-write state; an edge outside the configured sizes is not stored and sets
// edge_dropped for this graph. A request with last_edge set stores its edge if in range
// and then starts the count: every pair of left rows holding at least one edge is read
// through the single RAM read port, ANDed, and popcounted CHUNK_W bits per cycle by one
// shared unit; C(c,2) of each pair is added to a total that saturates at the maximum
// 22-bit value. An empty row a is skipped, a non-empty one is read and captured; for
// each a, an empty row b is skipped and a non-empty one is read and paired with row a.
// The input is not ready during the count. The result sits in an output register, so the
// next graph may start loading while it waits to be taken; the matrix and the dropped flag
// are emptied in the cycle the result is loaded. Row valid bits model the cleared matrix,
// so no clearing pass is needed after reset or after a result. Configuration writes are
// always accepted and take effect on the following request.
`include "bipartite_butterfly_counter_top_defines.svh"

module bipartite_butterfly_counter_top #(
  parameter int MAX_LEFT  = bbc_pkg::MAX_LEFT_DEF,
  parameter int MAX_RIGHT = bbc_pkg::MAX_RIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbc_pkg::CFG_W-1:0]       cfg_data,
  // edge request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bbc_pkg::VTX_W-1:0]       left_vertex,
  input  logic [bbc_pkg::VTX_W-1:0]       right_vertex,
  input  logic                            last_edge,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bbc_pkg::COUNT_W-1:0]     butterfly_count,
  output logic                            edge_dropped
);
  import bbc_pkg::*;

  localparam int LW = $clog2(MAX_LEFT);

  logic [CFG_W-1:0]     left_in_use;
  logic [CFG_W-1:0]     right_in_use;

  logic                 ram_wr_en;
  logic [LW-1:0]        ram_wr_addr;
  logic [MAX_RIGHT-1:0] ram_wr_data;
  logic [LW-1:0]        ram_rd_addr;
  logic [MAX_RIGHT-1:0] ram_rd_data;

  pair_ctrl_t           pair_ctl;
  logic                 chunk_last;
  logic [COUNT_W-1:0]   total;

  logic                 res_busy;
  logic                 res_load;
  logic                 res_dropped;

  // Configuration registers: always ready, writes outside the register list are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_in_use  <= CFG_RESET;
      right_in_use <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEFT_IN_USE:  left_in_use  <= cfg_data;
        REG_RIGHT_IN_USE: right_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Adjacency matrix, one row per left vertex
  bbc_ram #(
    .WIDTH (MAX_RIGHT),
    .DEPTH (MAX_LEFT)
  ) u_adj_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Shared popcount / C(c,2) / accumulate unit
  bbc_pair_unit #(
    .MAX_RIGHT (MAX_RIGHT)
  ) u_pair (
    .clk        (clk),
    .rst        (rst),
    .ctl        (pair_ctl),
    .rd_data    (ram_rd_data),
    .chunk_last (chunk_last),
    .total      (total)
  );

  // Sequencer for edge loading and the pair sweep
  bbc_ctrl #(
    .MAX_LEFT  (MAX_LEFT),
    .MAX_RIGHT (MAX_RIGHT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_vertex  (left_vertex),
    .right_vertex (right_vertex),
    .last_edge    (last_edge),
    .left_in_use  (left_in_use),
    .right_in_use (right_in_use),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .pair_ctl     (pair_ctl),
    .chunk_last   (chunk_last),
    .res_busy     (res_busy),
    .res_load     (res_load),
    .res_dropped  (res_dropped)
  );

  // Result register: hold until taken; a new result loads only into a free slot
  assign res_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      butterfly_count <= total;
      edge_dropped    <= res_dropped;
    end
  end

  // Never overwrite a result that is still waiting
  `BBC_ASSERT_IMPLY(a_no_result_overwrite, clk, rst, res_load, !res_busy)
  // A final edge always starts the count, so the input drops ready straight after it
  `BBC_ASSERT_NEXT(a_last_edge_blocks, clk, rst, in_valid && in_ready && last_edge, !in_ready)
  // Loading a result empties the running total for the next graph
  `BBC_ASSERT_NEXT(a_total_cleared, clk, rst, res_load, total == '0)

endmodule

// ===== sim/bipartite_butterfly_counter_top_tb.sv =====
// Self-checking testbench for bipartite_butterfly_counter_top: loads edge graphs, predicts
// each butterfly total in a small scoreboard class and checks every result request.
// Depends on bbc_pkg and the bipartite_butterfly_counter_top RTL only.
module bipartite_butterfly_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int ROWS        = MAX_LEFT_DEF;
  localparam int COLS        = MAX_RIGHT_DEF;
  localparam int ITEM_TARGET = 950;
  // long enough to cover any edge still in flight
  localparam int SETTLE      = 16;

  // indexes that map to no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } graph_total_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT} rx_mode_t;

  // Shadow copy of the adjacency matrix and the size registers, plus the queue of
  // butterfly totals still owed by the block.
  class butterfly_ledger;
    bit [COLS-1:0]  rows [ROWS];
    bit             dropped;
    bit [CFG_W-1:0] left_size;
    bit [CFG_W-1:0] right_size;
    graph_total_t   pending_totals[$];
    int             faults;

    function new();
      foreach (rows[i]) rows[i] = '0;
      dropped    = 1'b0;
      left_size  = CFG_RESET;
      right_size = CFG_RESET;
      faults     = 0;
    endfunction

    function int rows_in_use();
      return (left_size > ROWS) ? ROWS : int'(left_size);
    endfunction

    function int cols_in_use();
      return (right_size > COLS) ? COLS : int'(right_size);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_LEFT_IN_USE) left_size = value;
      else if (idx == REG_RIGHT_IN_USE) right_size = value;
    endfunction

    function void take_edge(logic [VTX_W-1:0] lv, logic [VTX_W-1:0] rv, logic last);
      graph_total_t t;
      int           total;
      int           common;
      if (int'(lv) < rows_in_use() && int'(rv) < cols_in_use()) rows[lv][rv] = 1'b1;
      else dropped = 1'b1;
      if (last) begin
        total = 0;
        for (int a = 0; a < ROWS; a++) begin
          for (int b = a + 1; b < ROWS; b++) begin
            common = $countones(rows[a] & rows[b]);
            total += common * (common - 1) / 2;
          end
        end
        t.count   = (total > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(total);
        t.dropped = dropped;
        pending_totals.insert(pending_totals.size(), t);
        foreach (rows[i]) rows[i] = '0;
        dropped = 1'b0;
      end
    endfunction

    task flag_fault(string msg);
      $display("%0t ns: %s", $time, msg);
      faults++;
    endtask

    task match_count(logic [COUNT_W-1:0] count, logic dropped_seen);
      graph_total_t t;
      if (pending_totals.size() == 0) begin
        flag_fault($sformatf("unexpected result count=%0d dropped=%0b", count, dropped_seen));
      end else begin
        t = pending_totals.pop_front();
        if (count !== t.count)
          flag_fault($sformatf("butterfly_count got %0d want %0d", count, t.count));
        if (dropped_seen !== t.dropped)
          flag_fault($sformatf("edge_dropped got %0b want %0b", dropped_seen, t.dropped));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [VTX_W-1:0]     left_vertex;
  logic [VTX_W-1:0]     right_vertex;
  logic                 last_edge;
  logic                 out_valid;
  logic                 out_ready;
  logic [COUNT_W-1:0]   butterfly_count;
  logic                 edge_dropped;

  butterfly_ledger ledger = new();
  int              items_sent = 0;
  int              burst_left = 0;

  bipartite_butterfly_counter_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .left_vertex    (left_vertex),
    .right_vertex   (right_vertex),
    .last_edge      (last_edge),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .butterfly_count(butterfly_count),
    .edge_dropped   (edge_dropped)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Present one edge request on the falling edge and hold it until the block takes it.
  // Back-to-back calls keep valid high and only swap the payload.
  task automatic send_edge(input logic [VTX_W-1:0] lv, input logic [VTX_W-1:0] rv,
                           input logic last);
    @(negedge clk);
    in_valid     = 1'b1;
    left_vertex  = lv;
    right_vertex = rv;
    last_edge    = last;
    do @(posedge clk); while (!in_ready);
    ledger.take_edge(lv, rv, last);
    items_sent++;
  endtask

  // Drop valid for a number of cycles.
  task automatic hold_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Send in bursts: after each burst idle for a random gap, sometimes with long runs
  // of requests and no gap at all.
  task automatic push_edge(input logic [VTX_W-1:0] lv, input logic [VTX_W-1:0] rv,
                           input logic last);
    send_edge(lv, rv, last);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      hold_sender($urandom_range(1, 10));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Stop sending and wait until every owed total has come back, then let any edge
  // still being written settle before the block is treated as idle.
  task automatic drain_block();
    hold_sender(1);
    while (ledger.pending_totals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write on its own channel; call only while the block is idle.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return CFG_W'(1);
      1:       return CFG_W'(64);
      2:       return CFG_W'(0);
      3:       return CFG_W'($urandom_range(65, 127));
      default: return CFG_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Directed graphs: field extremes, repeated edges, dropped edges, sizes above the
  // parameter, a zero size, and a size change in the middle of a graph.
  task automatic directed_graphs();
    // corners of the full matrix, with a repeated edge: one butterfly
    push_edge(6'd0, 6'd0, 1'b0);
    push_edge(6'd0, 6'd0, 1'b0);
    push_edge(6'd0, 6'd63, 1'b0);
    push_edge(6'd63, 6'd0, 1'b0);
    push_edge(6'd63, 6'd63, 1'b1);
    drain_block();
    // two rows only, right size above the parameter; one edge falls outside
    write_cfg(REG_LEFT_IN_USE, 7'd2);
    write_cfg(REG_RIGHT_IN_USE, 7'd127);
    push_edge(6'd1, 6'd63, 1'b0);
    push_edge(6'd0, 6'd63, 1'b0);
    push_edge(6'd2, 6'd5, 1'b0);
    push_edge(6'd1, 6'd62, 1'b0);
    push_edge(6'd0, 6'd62, 1'b1);
    drain_block();
    // zero rows: everything is dropped
    write_cfg(REG_LEFT_IN_USE, 7'd0);
    push_edge(6'd0, 6'd0, 1'b1);
    drain_block();
    // spare indexes must leave both sizes alone
    write_cfg(REG_LEFT_IN_USE, 7'd2);
    write_cfg(REG_RIGHT_IN_USE, 7'd2);
    write_cfg(REG_SPARE_A, 7'd1);
    write_cfg(REG_SPARE_B, 7'd0);
    push_edge(6'd0, 6'd0, 1'b0);
    push_edge(6'd0, 6'd1, 1'b0);
    push_edge(6'd1, 6'd0, 1'b0);
    push_edge(6'd1, 6'd1, 1'b0);
    // shrink mid-graph: stored edges stay, new ones outside are dropped
    drain_block();
    write_cfg(REG_LEFT_IN_USE, 7'd1);
    write_cfg(REG_RIGHT_IN_USE, 7'd1);
    push_edge(6'd1, 6'd1, 1'b0);
    push_edge(6'd0, 6'd0, 1'b1);
    drain_block();
    write_cfg(REG_LEFT_IN_USE, 7'd64);
    write_cfg(REG_RIGHT_IN_USE, 7'd64);
  endtask

  // One random graph: edges mostly inside a small window so butterflies are common,
  // some graphs spread edges over all rows in use to exercise the full pair sweep, and a few edges
  // land anywhere as noise.
  task automatic random_graph();
    int               n;
    int               shape;
    int               lsz;
    int               rsz;
    int               lb;
    int               ls;
    int               cb;
    int               cs;
    logic [VTX_W-1:0] lv;
    logic [VTX_W-1:0] rv;
    lsz   = ledger.rows_in_use();
    rsz   = ledger.cols_in_use();
    if (lsz == 0) lsz = 1;
    if (rsz == 0) rsz = 1;
    shape = $urandom_range(0, 19);
    if (shape == 0) n = $urandom_range(64, 90);
    else if (shape <= 2) n = $urandom_range(40, 80);
    else n = $urandom_range(1, 25);
    ls = $urandom_range(2, 8);
    cs = $urandom_range(2, 8);
    if (ls > lsz) ls = lsz;
    if (cs > rsz) cs = rsz;
    lb = $urandom_range(0, lsz - ls);
    cb = $urandom_range(0, rsz - cs);
    if (shape == 0) begin
      lb = 0;
      ls = lsz;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        lv = VTX_W'($urandom_range(0, 63));
        rv = VTX_W'($urandom_range(0, 63));
      end else begin
        lv = VTX_W'(lb + $urandom_range(0, ls - 1));
        rv = VTX_W'(cb + $urandom_range(0, cs - 1));
      end
      push_edge(lv, rv, i == n - 1);
    end
  endtask

  // Receiver: switch between always ready, coin-flip ready and tight stalls.
  initial begin
    rx_mode_t mode;
    int       span;
    out_ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(50, 400);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_OPEN: out_ready = 1'b1;
          RX_COIN: out_ready = 1'($urandom_range(0, 1));
          default: out_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Check every result request taken at a rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) ledger.match_count(butterfly_count, edge_dropped);
  end

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = REG_LEFT_IN_USE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    left_vertex  = '0;
    right_vertex = '0;
    last_edge    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_graphs();

    while (items_sent < ITEM_TARGET) begin
      // now and then idle the block completely and move to new sizes
      if ($urandom_range(0, 3) == 0) begin
        drain_block();
        if ($urandom_range(0, 2) != 0) write_cfg(REG_LEFT_IN_USE, pick_size());
        if ($urandom_range(0, 2) != 0) write_cfg(REG_RIGHT_IN_USE, pick_size());
      end
      random_graph();
    end

    drain_block();
    repeat (50) @(posedge clk);
    if (ledger.faults == 0) $display("bipartite_butterfly_counter_top: match");
    else $display("bipartite_butterfly_counter_top: mismatch");
    $finish;
  end

  // Give up on a hung block; far beyond the slowest legal run.
  initial begin
    #400_000_000;
    $display("bipartite_butterfly_counter_top: mismatch");
    $finish;
  end

endmodule
